// ===== rtl/core/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths, hue constants and stage payload types for the rgb to hsv
// converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // component width
  localparam int CB = 8;
  // quotient bits per division: hue part needs 12 (up to 3840), saturation needs CB
  localparam int NC = (CB > 12) ? CB : 12;
  // dividend width: CB remainder bits on top of NC quotient bits
  localparam int DVD_W = CB + NC;
  // hue field width
  localparam int HW = 15;

  localparam int IN_DATA_W  = ((3 * CB + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HW + 2 * CB + 7) / 8) * 8;

  // hue in 1/64 degree
  localparam logic [HW-1:0] HUE_SECTOR = HW'(3840);
  localparam logic [HW-1:0] HUE_GREEN  = HW'(7680);
  localparam logic [HW-1:0] HUE_BLUE   = HW'(15360);
  localparam logic [HW-1:0] HUE_FULL   = HW'(23040);

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } rhc_sector_t;

  // partial remainder plus dividend/quotient shift word
  typedef struct packed {
    logic [CB-1:0] rem;
    logic [NC-1:0] dq;
  } rhc_div_t;

  typedef struct packed {
    rhc_div_t      sat;
    logic [CB-1:0] mx;
    rhc_div_t      hue;
    logic [CB-1:0] delta;
    rhc_sector_t   sector;
    logic          neg;
  } rhc_cell_t;

endpackage

// ===== rtl/core/rgb_to_hsv_convert_top.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_top
// RGB to HSV conversion of a pixel stream, one pixel per clock if not stalled.
//
// Each pixel is converted in a fixed pipeline of rhc_pkg::NC + 2 stages: a
// front stage finds max, min, the hue sector and both dividends, a row of NC
// identical division cells then produces one quotient bit per cell for
// saturation and hue side by side, and an output stage applies the sector
// offset and registers the result. A new pixel can be taken every clock
// while out_tready does not stall. Each stage holds its own valid bit and
// moves forward whenever the next stage is empty or moving, so bubbles close
// up and input keeps flowing into empty stages while a finished result
// waits on out_tready. Value is the largest component, saturation
// floor(255*delta/max), hue in 1/64 degree (0..23039); for gray or black
// hue and saturation read 0 and out_tuser is 0.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // red, green, blue from bit 0 up
  input  logic [rhc_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // hue, saturation, value from bit 0 up, zero padded
  output logic [rhc_pkg::OUT_DATA_W-1:0] out_tdata,
  // hue_defined
  output logic                           out_tuser
);
  import rhc_pkg::*;

  // link i feeds cell i; link NC feeds the output stage
  logic      link_valid [NC+1];
  logic      link_ready [NC+1];
  rhc_cell_t link_data  [NC+1];

  // front stage
  rhc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // one quotient bit per cell, msb first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_ready (link_ready[i]),
      .up_data  (link_data[i]),
      .dn_valid (link_valid[i+1]),
      .dn_ready (link_ready[i+1]),
      .dn_data  (link_data[i+1])
    );
  end

  // sector offset and result register
  rhc_finish u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (link_valid[NC]),
    .up_ready (link_ready[NC]),
    .up_data  (link_data[NC]),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata),
    .dn_user  (out_tuser)
  );

endmodule

// ===== rtl/core/rhc_prep.sv =====
// ----------------------------------------------------------------------------
// rhc_prep
// Front stage: max, min, sector, signed difference and both dividends.
// ----------------------------------------------------------------------------
module rhc_prep (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic [rhc_pkg::IN_DATA_W-1:0]   up_data,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output rhc_pkg::rhc_cell_t              dn_data
);
  import rhc_pkg::*;

  logic [CB-1:0]    red, green, blue;
  logic [CB-1:0]    mx, mn, delta, abs_diff;
  logic signed [CB:0] diff;
  logic             neg;
  rhc_sector_t      sector;
  logic [DVD_W-1:0] sat_dvd, hue_dvd;
  rhc_cell_t        data_nxt, data_r;
  logic             valid_r;

  assign red   = up_data[CB-1:0];
  assign green = up_data[2*CB-1:CB];
  assign blue  = up_data[3*CB-1:2*CB];

  always_comb begin
    // ties: red over green, green over blue
    if (red >= green && red >= blue) begin
      sector = SEC_RED;
      mx     = red;
      diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green >= blue) begin
      sector = SEC_GREEN;
      mx     = green;
      diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sector = SEC_BLUE;
      mx     = blue;
      diff   = $signed({1'b0, red}) - $signed({1'b0, green});
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta    = mx - mn;
    neg      = diff[CB];
    abs_diff = neg ? CB'(-diff) : diff[CB-1:0];
    // full-scale times delta, and sector width times |diff|
    sat_dvd  = DVD_W'({delta, CB'(0)}) - DVD_W'(delta);
    hue_dvd  = DVD_W'(abs_diff) * DVD_W'(HUE_SECTOR);

    data_nxt.sat.rem = sat_dvd[DVD_W-1:NC];
    data_nxt.sat.dq  = sat_dvd[NC-1:0];
    data_nxt.mx      = mx;
    data_nxt.hue.rem = hue_dvd[DVD_W-1:NC];
    data_nxt.hue.dq  = hue_dvd[NC-1:0];
    data_nxt.delta   = delta;
    data_nxt.sector  = sector;
    data_nxt.neg     = neg;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/rhc_div_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_div_cell
// One restoring division step for both saturation and hue, one quotient bit.
// ----------------------------------------------------------------------------
module rhc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rhc_pkg::rhc_cell_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rhc_pkg::rhc_cell_t dn_data
);
  import rhc_pkg::*;

  function automatic rhc_div_t div_step(input rhc_div_t s, input logic [CB-1:0] d);
    logic [CB:0] part;
    logic [CB:0] trial;
    rhc_div_t    o;
    part  = {s.rem, s.dq[NC-1]};
    trial = part - {1'b0, d};
    // top bit set means part < d: restore
    o.rem = trial[CB] ? part[CB-1:0] : trial[CB-1:0];
    o.dq  = {s.dq[NC-2:0], ~trial[CB]};
    return o;
  endfunction

  rhc_cell_t data_nxt, data_r;
  logic      valid_r;

  always_comb begin
    data_nxt     = up_data;
    data_nxt.sat = div_step(up_data.sat, up_data.mx);
    data_nxt.hue = div_step(up_data.hue, up_data.delta);
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/core/rhc_finish.sv =====
// ----------------------------------------------------------------------------
// rhc_finish
// Output stage: sector offset, rounding fix-up, special cases, result register.
// ----------------------------------------------------------------------------
module rhc_finish (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  rhc_pkg::rhc_cell_t             up_data,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output logic [rhc_pkg::OUT_DATA_W-1:0] dn_data,
  output logic                           dn_user
);
  import rhc_pkg::*;

  logic [HW-1:0] q, base, mag, hue_nxt, hue_r;
  logic          rem_nz, defined_nxt, defined_r;
  logic [CB-1:0] sat_nxt, sat_r, value_r;
  logic          valid_r;

  always_comb begin
    q      = HW'(up_data.hue.dq);
    rem_nz = |up_data.hue.rem;
    case (up_data.sector)
      SEC_RED: begin
        // truncation toward zero, wrap a negative angle
        base = up_data.neg ? HUE_FULL : '0;
        mag  = q;
      end
      SEC_GREEN: begin
        // numerator stays positive, so the quotient is floored
        base = HUE_GREEN;
        mag  = q + HW'(up_data.neg && rem_nz);
      end
      SEC_BLUE: begin
        base = HUE_BLUE;
        mag  = q + HW'(up_data.neg && rem_nz);
      end
      default: begin
        base = '0;
        mag  = '0;
      end
    endcase
    defined_nxt = |up_data.delta;
    if (!defined_nxt) begin
      hue_nxt = '0;
    end else if (up_data.sector == SEC_RED && up_data.neg && q == '0) begin
      hue_nxt = '0;
    end else if (up_data.neg) begin
      hue_nxt = base - mag;
    end else begin
      hue_nxt = base + mag;
    end
    sat_nxt = (up_data.mx == '0) ? '0 : up_data.sat.dq[CB-1:0];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      hue_r     <= hue_nxt;
      defined_r <= defined_nxt;
      sat_r     <= sat_nxt;
      value_r   <= up_data.mx;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = OUT_DATA_W'({value_r, sat_r, hue_r});
  assign dn_user  = defined_r;

endmodule
